### src/blowfish_block_cipher_defines.svh
// ---------------------------------------------------------------------------
// Blowfish block cipher assertion macros
// Shared assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef BLOWFISH_BLOCK_CIPHER_DEFINES_SVH
`define BLOWFISH_BLOCK_CIPHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/bf_pkg.sv
// ---------------------------------------------------------------------------
// Blowfish package
// Types, command codes and the pi initialization tables.
// ---------------------------------------------------------------------------
package bf_pkg;

  localparam int ROUNDS   = 16;
  localparam int P_LEN    = ROUNDS + 2;
  localparam int S_LEN    = 1024;
  localparam int KXOR_LEN = P_LEN * 4;

  localparam logic [4:0] P_FIRST = 5'd0;
  localparam logic [4:0] P_LAST  = 5'(P_LEN - 1);

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_SCHED = 2'd1;
  localparam logic [1:0] KIND_ENC   = 2'd2;
  localparam logic [1:0] KIND_DEC   = 2'd3;

  localparam logic [1:0] SRC_INPUT = 2'd0;
  localparam logic [1:0] SRC_ZERO  = 2'd1;
  localparam logic [1:0] SRC_CHAIN = 2'd2;

  typedef struct packed {
    logic       p_load_rom;
    logic       key_wr;
    logic       key_shift;
    logic       p_xor_key;
    logic       blk_start;
    logic [1:0] blk_src;
    logic       round;
    logic       finish;
    logic       p_wr_pair;
    logic       s_clear;
    logic       s_wr;
    logic       s_wr_hi;
    logic [9:0] s_idx;
    logic [4:0] p_idx;
    logic       out_load;
  } bf_cmd_t;

  typedef struct packed {
    logic out_free;
  } bf_status_t;

  localparam logic [31:0] P_INIT [P_LEN] = '{
    32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344, 32'ha4093822, 32'h299f31d0,
    32'h082efa98, 32'hec4e6c89, 32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
    32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917, 32'h9216d5d9, 32'h8979fb1b
  };

  localparam logic [31:0] S_INIT [S_LEN] = '{
    32'hd1310ba6, 32'h98dfb5ac, 32'h2ffd72db, 32'hd01adfb7, 32'hb8e1afed, 32'h6a267e96,
    32'hba7c9045, 32'hf12c7f99, 32'h24a19947, 32'hb3916cf7, 32'h0801f2e2, 32'h858efc16,
    32'h636920d8, 32'h71574e69, 32'ha458fea3, 32'hf4933d7e, 32'h0d95748f, 32'h728eb658,
    32'h718bcd58, 32'h82154aee, 32'h7b54a41d, 32'hc25a59b5, 32'h9c30d539, 32'h2af26013,
    32'hc5d1b023, 32'h286085f0, 32'hca417918, 32'hb8db38ef, 32'h8e79dcb0, 32'h603a180e,
    32'h6c9e0e8b, 32'hb01e8a3e, 32'hd71577c1, 32'hbd314b27, 32'h78af2fda, 32'h55605c60,
    32'he65525f3, 32'haa55ab94, 32'h57489862, 32'h63e81440, 32'h55ca396a, 32'h2aab10b6,
    32'hb4cc5c34, 32'h1141e8ce, 32'ha15486af, 32'h7c72e993, 32'hb3ee1411, 32'h636fbc2a,
    32'h2ba9c55d, 32'h741831f6, 32'hce5c3e16, 32'h9b87931e, 32'hafd6ba33, 32'h6c24cf5c,
    32'h7a325381, 32'h28958677, 32'h3b8f4898, 32'h6b4bb9af, 32'hc4bfe81b, 32'h66282193,
    32'h61d809cc, 32'hfb21a991, 32'h487cac60, 32'h5dec8032, 32'hef845d5d, 32'he98575b1,
    32'hdc262302, 32'heb651b88, 32'h23893e81, 32'hd396acc5, 32'h0f6d6ff3, 32'h83f44239,
    32'h2e0b4482, 32'ha4842004, 32'h69c8f04a, 32'h9e1f9b5e, 32'h21c66842, 32'hf6e96c9a,
    32'h670c9c61, 32'habd388f0, 32'h6a51a0d2, 32'hd8542f68, 32'h960fa728, 32'hab5133a3,
    32'h6eef0b6c, 32'h137a3be4, 32'hba3bf050, 32'h7efb2a98, 32'ha1f1651d, 32'h39af0176,
    32'h66ca593e, 32'h82430e88, 32'h8cee8619, 32'h456f9fb4, 32'h7d84a5c3, 32'h3b8b5ebe,
    32'he06f75d8, 32'h85c12073, 32'h401a449f, 32'h56c16aa6, 32'h4ed3aa62, 32'h363f7706,
    32'h1bfedf72, 32'h429b023d, 32'h37d0d724, 32'hd00a1248, 32'hdb0fead3, 32'h49f1c09b,
    32'h075372c9, 32'h80991b7b, 32'h25d479d8, 32'hf6e8def7, 32'he3fe501a, 32'hb6794c3b,
    32'h976ce0bd, 32'h04c006ba, 32'hc1a94fb6, 32'h409f60c4, 32'h5e5c9ec2, 32'h196a2463,
    32'h68fb6faf, 32'h3e6c53b5, 32'h1339b2eb, 32'h3b52ec6f, 32'h6dfc511f, 32'h9b30952c,
    32'hcc814544, 32'haf5ebd09, 32'hbee3d004, 32'hde334afd, 32'h660f2807, 32'h192e4bb3,
    32'hc0cba857, 32'h45c8740f, 32'hd20b5f39, 32'hb9d3fbdb, 32'h5579c0bd, 32'h1a60320a,
    32'hd6a100c6, 32'h402c7279, 32'h679f25fe, 32'hfb1fa3cc, 32'h8ea5e9f8, 32'hdb3222f8,
    32'h3c7516df, 32'hfd616b15, 32'h2f501ec8, 32'had0552ab, 32'h323db5fa, 32'hfd238760,
    32'h53317b48, 32'h3e00df82, 32'h9e5c57bb, 32'hca6f8ca0, 32'h1a87562e, 32'hdf1769db,
    32'hd542a8f6, 32'h287effc3, 32'hac6732c6, 32'h8c4f5573, 32'h695b27b0, 32'hbbca58c8,
    32'he1ffa35d, 32'hb8f011a0, 32'h10fa3d98, 32'hfd2183b8, 32'h4afcb56c, 32'h2dd1d35b,
    32'h9a53e479, 32'hb6f84565, 32'hd28e49bc, 32'h4bfb9790, 32'he1ddf2da, 32'ha4cb7e33,
    32'h62fb1341, 32'hcee4c6e8, 32'hef20cada, 32'h36774c01, 32'hd07e9efe, 32'h2bf11fb4,
    32'h95dbda4d, 32'hae909198, 32'heaad8e71, 32'h6b93d5a0, 32'hd08ed1d0, 32'hafc725e0,
    32'h8e3c5b2f, 32'h8e7594b7, 32'h8ff6e2fb, 32'hf2122b64, 32'h8888b812, 32'h900df01c,
    32'h4fad5ea0, 32'h688fc31c, 32'hd1cff191, 32'hb3a8c1ad, 32'h2f2f2218, 32'hbe0e1777,
    32'hea752dfe, 32'h8b021fa1, 32'he5a0cc0f, 32'hb56f74e8, 32'h18acf3d6, 32'hce89e299,
    32'hb4a84fe0, 32'hfd13e0b7, 32'h7cc43b81, 32'hd2ada8d9, 32'h165fa266, 32'h80957705,
    32'h93cc7314, 32'h211a1477, 32'he6ad2065, 32'h77b5fa86, 32'hc75442f5, 32'hfb9d35cf,
    32'hebcdaf0c, 32'h7b3e89a0, 32'hd6411bd3, 32'hae1e7e49, 32'h00250e2d, 32'h2071b35e,
    32'h226800bb, 32'h57b8e0af, 32'h2464369b, 32'hf009b91e, 32'h5563911d, 32'h59dfa6aa,
    32'h78c14389, 32'hd95a537f, 32'h207d5ba2, 32'h02e5b9c5, 32'h83260376, 32'h6295cfa9,
    32'h11c81968, 32'h4e734a41, 32'hb3472dca, 32'h7b14a94a, 32'h1b510052, 32'h9a532915,
    32'hd60f573f, 32'hbc9bc6e4, 32'h2b60a476, 32'h81e67400, 32'h08ba6fb5, 32'h571be91f,
    32'hf296ec6b, 32'h2a0dd915, 32'hb6636521, 32'he7b9f9b6, 32'hff34052e, 32'hc5855664,
    32'h53b02d5d, 32'ha99f8fa1, 32'h08ba4799, 32'h6e85076a,
    32'h4b7a70e9, 32'hb5b32944, 32'hdb75092e, 32'hc4192623, 32'had6ea6b0, 32'h49a7df7d,
    32'h9cee60b8, 32'h8fedb266, 32'hecaa8c71, 32'h699a17ff, 32'h5664526c, 32'hc2b19ee1,
    32'h193602a5, 32'h75094c29, 32'ha0591340, 32'he4183a3e, 32'h3f54989a, 32'h5b429d65,
    32'h6b8fe4d6, 32'h99f73fd6, 32'ha1d29c07, 32'hefe830f5, 32'h4d2d38e6, 32'hf0255dc1,
    32'h4cdd2086, 32'h8470eb26, 32'h6382e9c6, 32'h021ecc5e, 32'h09686b3f, 32'h3ebaefc9,
    32'h3c971814, 32'h6b6a70a1, 32'h687f3584, 32'h52a0e286, 32'hb79c5305, 32'haa500737,
    32'h3e07841c, 32'h7fdeae5c, 32'h8e7d44ec, 32'h5716f2b8, 32'hb03ada37, 32'hf0500c0d,
    32'hf01c1f04, 32'h0200b3ff, 32'hae0cf51a, 32'h3cb574b2, 32'h25837a58, 32'hdc0921bd,
    32'hd19113f9, 32'h7ca92ff6, 32'h94324773, 32'h22f54701, 32'h3ae5e581, 32'h37c2dadc,
    32'hc8b57634, 32'h9af3dda7, 32'ha9446146, 32'h0fd0030e, 32'hecc8c73e, 32'ha4751e41,
    32'he238cd99, 32'h3bea0e2f, 32'h3280bba1, 32'h183eb331, 32'h4e548b38, 32'h4f6db908,
    32'h6f420d03, 32'hf60a04bf, 32'h2cb81290, 32'h24977c79, 32'h5679b072, 32'hbcaf89af,
    32'hde9a771f, 32'hd9930810, 32'hb38bae12, 32'hdccf3f2e, 32'h5512721f, 32'h2e6b7124,
    32'h501adde6, 32'h9f84cd87, 32'h7a584718, 32'h7408da17, 32'hbc9f9abc, 32'he94b7d8c,
    32'hec7aec3a, 32'hdb851dfa, 32'h63094366, 32'hc464c3d2, 32'hef1c1847, 32'h3215d908,
    32'hdd433b37, 32'h24c2ba16, 32'h12a14d43, 32'h2a65c451, 32'h50940002, 32'h133ae4dd,
    32'h71dff89e, 32'h10314e55, 32'h81ac77d6, 32'h5f11199b, 32'h043556f1, 32'hd7a3c76b,
    32'h3c11183b, 32'h5924a509, 32'hf28fe6ed, 32'h97f1fbfa, 32'h9ebabf2c, 32'h1e153c6e,
    32'h86e34570, 32'heae96fb1, 32'h860e5e0a, 32'h5a3e2ab3, 32'h771fe71c, 32'h4e3d06fa,
    32'h2965dcb9, 32'h99e71d0f, 32'h803e89d6, 32'h5266c825, 32'h2e4cc978, 32'h9c10b36a,
    32'hc6150eba, 32'h94e2ea78, 32'ha5fc3c53, 32'h1e0a2df4, 32'hf2f74ea7, 32'h361d2b3d,
    32'h1939260f, 32'h19c27960, 32'h5223a708, 32'hf71312b6, 32'hebadfe6e, 32'heac31f66,
    32'he3bc4595, 32'ha67bc883, 32'hb17f37d1, 32'h018cff28, 32'hc332ddef, 32'hbe6c5aa5,
    32'h65582185, 32'h68ab9802, 32'heecea50f, 32'hdb2f953b, 32'h2aef7dad, 32'h5b6e2f84,
    32'h1521b628, 32'h29076170, 32'hecdd4775, 32'h619f1510, 32'h13cca830, 32'heb61bd96,
    32'h0334fe1e, 32'haa0363cf, 32'hb5735c90, 32'h4c70a239, 32'hd59e9e0b, 32'hcbaade14,
    32'heecc86bc, 32'h60622ca7, 32'h9cab5cab, 32'hb2f3846e, 32'h648b1eaf, 32'h19bdf0ca,
    32'ha02369b9, 32'h655abb50, 32'h40685a32, 32'h3c2ab4b3, 32'h319ee9d5, 32'hc021b8f7,
    32'h9b540b19, 32'h875fa099, 32'h95f7997e, 32'h623d7da8, 32'hf837889a, 32'h97e32d77,
    32'h11ed935f, 32'h16681281, 32'h0e358829, 32'hc7e61fd6, 32'h96dedfa1, 32'h7858ba99,
    32'h57f584a5, 32'h1b227263, 32'h9b83c3ff, 32'h1ac24696, 32'hcdb30aeb, 32'h532e3054,
    32'h8fd948e4, 32'h6dbc3128, 32'h58ebf2ef, 32'h34c6ffea, 32'hfe28ed61, 32'hee7c3c73,
    32'h5d4a14d9, 32'he864b7e3, 32'h42105d14, 32'h203e13e0, 32'h45eee2b6, 32'ha3aaabea,
    32'hdb6c4f15, 32'hfacb4fd0, 32'hc742f442, 32'hef6abbb5, 32'h654f3b1d, 32'h41cd2105,
    32'hd81e799e, 32'h86854dc7, 32'he44b476a, 32'h3d816250, 32'hcf62a1f2, 32'h5b8d2646,
    32'hfc8883a0, 32'hc1c7b6a3, 32'h7f1524c3, 32'h69cb7492, 32'h47848a0b, 32'h5692b285,
    32'h095bbf00, 32'had19489d, 32'h1462b174, 32'h23820e00, 32'h58428d2a, 32'h0c55f5ea,
    32'h1dadf43e, 32'h233f7061, 32'h3372f092, 32'h8d937e41, 32'hd65fecf1, 32'h6c223bdb,
    32'h7cde3759, 32'hcbee7460, 32'h4085f2a7, 32'hce77326e, 32'ha6078084, 32'h19f8509e,
    32'he8efd855, 32'h61d99735, 32'ha969a7aa, 32'hc50c06c2, 32'h5a04abfc, 32'h800bcadc,
    32'h9e447a2e, 32'hc3453484, 32'hfdd56705, 32'h0e1e9ec9, 32'hdb73dbd3, 32'h105588cd,
    32'h675fda79, 32'he3674340, 32'hc5c43465, 32'h713e38d8, 32'h3d28f89e, 32'hf16dff20,
    32'h153e21e7, 32'h8fb03d4a, 32'he6e39f2b, 32'hdb83adf7,
    32'he93d5a68, 32'h948140f7, 32'hf64c261c, 32'h94692934, 32'h411520f7, 32'h7602d4f7,
    32'hbcf46b2e, 32'hd4a20068, 32'hd4082471, 32'h3320f46a, 32'h43b7d4b7, 32'h500061af,
    32'h1e39f62e, 32'h97244546, 32'h14214f74, 32'hbf8b8840, 32'h4d95fc1d, 32'h96b591af,
    32'h70f4ddd3, 32'h66a02f45, 32'hbfbc09ec, 32'h03bd9785, 32'h7fac6dd0, 32'h31cb8504,
    32'h96eb27b3, 32'h55fd3941, 32'hda2547e6, 32'habca0a9a, 32'h28507825, 32'h530429f4,
    32'h0a2c86da, 32'he9b66dfb, 32'h68dc1462, 32'hd7486900, 32'h680ec0a4, 32'h27a18dee,
    32'h4f3ffea2, 32'he887ad8c, 32'hb58ce006, 32'h7af4d6b6, 32'haace1e7c, 32'hd3375fec,
    32'hce78a399, 32'h406b2a42, 32'h20fe9e35, 32'hd9f385b9, 32'hee39d7ab, 32'h3b124e8b,
    32'h1dc9faf7, 32'h4b6d1856, 32'h26a36631, 32'heae397b2, 32'h3a6efa74, 32'hdd5b4332,
    32'h6841e7f7, 32'hca7820fb, 32'hfb0af54e, 32'hd8feb397, 32'h454056ac, 32'hba489527,
    32'h55533a3a, 32'h20838d87, 32'hfe6ba9b7, 32'hd096954b, 32'h55a867bc, 32'ha1159a58,
    32'hcca92963, 32'h99e1db33, 32'ha62a4a56, 32'h3f3125f9, 32'h5ef47e1c, 32'h9029317c,
    32'hfdf8e802, 32'h04272f70, 32'h80bb155c, 32'h05282ce3, 32'h95c11548, 32'he4c66d22,
    32'h48c1133f, 32'hc70f86dc, 32'h07f9c9ee, 32'h41041f0f, 32'h404779a4, 32'h5d886e17,
    32'h325f51eb, 32'hd59bc0d1, 32'hf2bcc18f, 32'h41113564, 32'h257b7834, 32'h602a9c60,
    32'hdff8e8a3, 32'h1f636c1b, 32'h0e12b4c2, 32'h02e1329e, 32'haf664fd1, 32'hcad18115,
    32'h6b2395e0, 32'h333e92e1, 32'h3b240b62, 32'heebeb922, 32'h85b2a20e, 32'he6ba0d99,
    32'hde720c8c, 32'h2da2f728, 32'hd0127845, 32'h95b794fd, 32'h647d0862, 32'he7ccf5f0,
    32'h5449a36f, 32'h877d48fa, 32'hc39dfd27, 32'hf33e8d1e, 32'h0a476341, 32'h992eff74,
    32'h3a6f6eab, 32'hf4f8fd37, 32'ha812dc60, 32'ha1ebddf8, 32'h991be14c, 32'hdb6e6b0d,
    32'hc67b5510, 32'h6d672c37, 32'h2765d43b, 32'hdcd0e804, 32'hf1290dc7, 32'hcc00ffa3,
    32'hb5390f92, 32'h690fed0b, 32'h667b9ffb, 32'hcedb7d9c, 32'ha091cf0b, 32'hd9155ea3,
    32'hbb132f88, 32'h515bad24, 32'h7b9479bf, 32'h763bd6eb, 32'h37392eb3, 32'hcc115979,
    32'h8026e297, 32'hf42e312d, 32'h6842ada7, 32'hc66a2b3b, 32'h12754ccc, 32'h782ef11c,
    32'h6a124237, 32'hb79251e7, 32'h06a1bbe6, 32'h4bfb6350, 32'h1a6b1018, 32'h11caedfa,
    32'h3d25bdd8, 32'he2e1c3c9, 32'h44421659, 32'h0a121386, 32'hd90cec6e, 32'hd5abea2a,
    32'h64af674e, 32'hda86a85f, 32'hbebfe988, 32'h64e4c3fe, 32'h9dbc8057, 32'hf0f7c086,
    32'h60787bf8, 32'h6003604d, 32'hd1fd8346, 32'hf6381fb0, 32'h7745ae04, 32'hd736fccc,
    32'h83426b33, 32'hf01eab71, 32'hb0804187, 32'h3c005e5f, 32'h77a057be, 32'hbde8ae24,
    32'h55464299, 32'hbf582e61, 32'h4e58f48f, 32'hf2ddfda2, 32'hf474ef38, 32'h8789bdc2,
    32'h5366f9c3, 32'hc8b38e74, 32'hb475f255, 32'h46fcd9b9, 32'h7aeb2661, 32'h8b1ddf84,
    32'h846a0e79, 32'h915f95e2, 32'h466e598e, 32'h20b45770, 32'h8cd55591, 32'hc902de4c,
    32'hb90bace1, 32'hbb8205d0, 32'h11a86248, 32'h7574a99e, 32'hb77f19b6, 32'he0a9dc09,
    32'h662d09a1, 32'hc4324633, 32'he85a1f02, 32'h09f0be8c, 32'h4a99a025, 32'h1d6efe10,
    32'h1ab93d1d, 32'h0ba5a4df, 32'ha186f20f, 32'h2868f169, 32'hdcb7da83, 32'h573906fe,
    32'ha1e2ce9b, 32'h4fcd7f52, 32'h50115e01, 32'ha70683fa, 32'ha002b5c4, 32'h0de6d027,
    32'h9af88c27, 32'h773f8641, 32'hc3604c06, 32'h61a806b5, 32'hf0177a28, 32'hc0f586e0,
    32'h006058aa, 32'h30dc7d62, 32'h11e69ed7, 32'h2338ea63, 32'h53c2dd94, 32'hc2c21634,
    32'hbbcbee56, 32'h90bcb6de, 32'hebfc7da1, 32'hce591d76, 32'h6f05e409, 32'h4b7c0188,
    32'h39720a3d, 32'h7c927c24, 32'h86e3725f, 32'h724d9db9, 32'h1ac15bb4, 32'hd39eb8fc,
    32'hed545578, 32'h08fca5b5, 32'hd83d7cd3, 32'h4dad0fc4, 32'h1e50ef5e, 32'hb161e6f8,
    32'ha28514d9, 32'h6c51133c, 32'h6fd5c7e7, 32'h56e14ec4, 32'h362abfce, 32'hddc6c837,
    32'hd79a3234, 32'h92638212, 32'h670efa8e, 32'h406000e0,
    32'h3a39ce37, 32'hd3faf5cf, 32'habc27737, 32'h5ac52d1b, 32'h5cb0679e, 32'h4fa33742,
    32'hd3822740, 32'h99bc9bbe, 32'hd5118e9d, 32'hbf0f7315, 32'hd62d1c7e, 32'hc700c47b,
    32'hb78c1b6b, 32'h21a19045, 32'hb26eb1be, 32'h6a366eb4, 32'h5748ab2f, 32'hbc946e79,
    32'hc6a376d2, 32'h6549c2c8, 32'h530ff8ee, 32'h468dde7d, 32'hd5730a1d, 32'h4cd04dc6,
    32'h2939bbdb, 32'ha9ba4650, 32'hac9526e8, 32'hbe5ee304, 32'ha1fad5f0, 32'h6a2d519a,
    32'h63ef8ce2, 32'h9a86ee22, 32'hc089c2b8, 32'h43242ef6, 32'ha51e03aa, 32'h9cf2d0a4,
    32'h83c061ba, 32'h9be96a4d, 32'h8fe51550, 32'hba645bd6, 32'h2826a2f9, 32'ha73a3ae1,
    32'h4ba99586, 32'hef5562e9, 32'hc72fefd3, 32'hf752f7da, 32'h3f046f69, 32'h77fa0a59,
    32'h80e4a915, 32'h87b08601, 32'h9b09e6ad, 32'h3b3ee593, 32'he990fd5a, 32'h9e34d797,
    32'h2cf0b7d9, 32'h022b8b51, 32'h96d5ac3a, 32'h017da67d, 32'hd1cf3ed6, 32'h7c7d2d28,
    32'h1f9f25cf, 32'hadf2b89b, 32'h5ad6b472, 32'h5a88f54c, 32'he029ac71, 32'he019a5e6,
    32'h47b0acfd, 32'hed93fa9b, 32'he8d3c48d, 32'h283b57cc, 32'hf8d56629, 32'h79132e28,
    32'h785f0191, 32'hed756055, 32'hf7960e44, 32'he3d35e8c, 32'h15056dd4, 32'h88f46dba,
    32'h03a16125, 32'h0564f0bd, 32'hc3eb9e15, 32'h3c9057a2, 32'h97271aec, 32'ha93a072a,
    32'h1b3f6d9b, 32'h1e6321f5, 32'hf59c66fb, 32'h26dcf319, 32'h7533d928, 32'hb155fdf5,
    32'h03563482, 32'h8aba3cbb, 32'h28517711, 32'hc20ad9f8, 32'habcc5167, 32'hccad925f,
    32'h4de81751, 32'h3830dc8e, 32'h379d5862, 32'h9320f991, 32'hea7a90c2, 32'hfb3e7bce,
    32'h5121ce64, 32'h774fbe32, 32'ha8b6e37e, 32'hc3293d46, 32'h48de5369, 32'h6413e680,
    32'ha2ae0810, 32'hdd6db224, 32'h69852dfd, 32'h09072166, 32'hb39a460a, 32'h6445c0dd,
    32'h586cdecf, 32'h1c20c8ae, 32'h5bbef7dd, 32'h1b588d40, 32'hccd2017f, 32'h6bb4e3bb,
    32'hdda26a7e, 32'h3a59ff45, 32'h3e350a44, 32'hbcb4cdd5, 32'h72eacea8, 32'hfa6484bb,
    32'h8d6612ae, 32'hbf3c6f47, 32'hd29be463, 32'h542f5d9e, 32'haec2771b, 32'hf64e6370,
    32'h740e0d8d, 32'he75b1357, 32'hf8721671, 32'haf537d5d, 32'h4040cb08, 32'h4eb4e2cc,
    32'h34d2466a, 32'h0115af84, 32'he1b00428, 32'h95983a1d, 32'h06b89fb4, 32'hce6ea048,
    32'h6f3f3b82, 32'h3520ab82, 32'h011a1d4b, 32'h277227f8, 32'h611560b1, 32'he7933fdc,
    32'hbb3a792b, 32'h344525bd, 32'ha08839e1, 32'h51ce794b, 32'h2f32c9b7, 32'ha01fbac9,
    32'he01cc87e, 32'hbcc7d1f6, 32'hcf0111c3, 32'ha1e8aac7, 32'h1a908749, 32'hd44fbd9a,
    32'hd0dadecb, 32'hd50ada38, 32'h0339c32a, 32'hc6913667, 32'h8df9317c, 32'he0b12b4f,
    32'hf79e59b7, 32'h43f5bb3a, 32'hf2d519ff, 32'h27d9459c, 32'hbf97222c, 32'h15e6fc2a,
    32'h0f91fc71, 32'h9b941525, 32'hfae59361, 32'hceb69ceb, 32'hc2a86459, 32'h12baa8d1,
    32'hb6c1075e, 32'he3056a0c, 32'h10d25065, 32'hcb03a442, 32'he0ec6e0e, 32'h1698db3b,
    32'h4c98a0be, 32'h3278e964, 32'h9f1f9532, 32'he0d392df, 32'hd3a0342b, 32'h8971f21e,
    32'h1b0a7441, 32'h4ba3348c, 32'hc5be7120, 32'hc37632d8, 32'hdf359f8d, 32'h9b992f2e,
    32'he60b6f47, 32'h0fe3f11d, 32'he54cda54, 32'h1edad891, 32'hce6279cf, 32'hcd3e7e6f,
    32'h1618b166, 32'hfd2c1d05, 32'h848fd2c5, 32'hf6fb2299, 32'hf523f357, 32'ha6327623,
    32'h93a83531, 32'h56cccd02, 32'hacf08162, 32'h5a75ebb5, 32'h6e163697, 32'h88d273cc,
    32'hde966292, 32'h81b949d0, 32'h4c50901b, 32'h71c65614, 32'he6c6c7bd, 32'h327a140a,
    32'h45e1d006, 32'hc3f27b9a, 32'hc9aa53fd, 32'h62a80f00, 32'hbb25bfe2, 32'h35bdd2f6,
    32'h71126905, 32'hb2040222, 32'hb6cbcf7c, 32'hcd769c2b, 32'h53113ec0, 32'h1640e3d3,
    32'h38abbd60, 32'h2547adf0, 32'hba38209c, 32'hf746ce76, 32'h77afa1c5, 32'h20756060,
    32'h85cbfe4e, 32'h8ae88dd8, 32'h7aaaf9b0, 32'h4cf9aa7e, 32'h1948c25c, 32'h02fb8a8c,
    32'h01c36ae4, 32'hd6ebe1f9, 32'h90d4f869, 32'ha65cdea0, 32'h3f09252d, 32'hc208e69f,
    32'hb74e6132, 32'hce77e25b, 32'h578fdfe3, 32'h3ac372e6
  };

endpackage

### src/blowfish_block_cipher.sv
// ---------------------------------------------------------------------------
// Blowfish block cipher
// Sixteen-round Blowfish with on-chip key buffer and key schedule.
// ---------------------------------------------------------------------------
// The input stream carries one command per transfer, selected by in_tuser:
// append a key byte, run the key schedule, encrypt a block or decrypt a
// block. Only encrypt and decrypt produce a transfer on the output stream.
// A block is loaded on its accepting edge; each round is then an S-box
// read followed by the round update, and after the last round come the
// output whitening step and the load into the result register. No new
// command is taken until the last block is in the result register.
// The S-box memories with their registered read port set the round pace.
// Key bytes are taken one per cycle while idle. The key schedule reloads
// the P array and the S-boxes from the pi tables, mixes the key in one
// byte per cycle, and runs the 521 encryptions.
// After reset the block loads the S-boxes with in_tready low.
// The result sits in an output register; a new command is taken while it
// waits, and a finished block stalls until the register is free.
// ---------------------------------------------------------------------------
`include "blowfish_block_cipher_defines.svh"

module blowfish_block_cipher #(
  parameter int MAX_KEY_BYTES = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // key_byte, block_left, block_right
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // out_left, out_right
);

  bf_pkg::bf_cmd_t                  cmd;
  bf_pkg::bf_status_t               status;
  logic [$clog2(MAX_KEY_BYTES)-1:0] key_wr_addr;
  logic [$clog2(MAX_KEY_BYTES)-1:0] key_rd_addr;
  logic [1:0]                       in_kind;
  logic [31:0]                      out_left, out_right;

  assign in_kind = in_tuser;

  bf_ctrl #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_kind),
    .status      (status),
    .cmd         (cmd),
    .key_wr_addr (key_wr_addr),
    .key_rd_addr (key_rd_addr)
  );

  bf_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .key_wr_addr (key_wr_addr),
    .key_rd_addr (key_rd_addr),
    .key_byte    (in_tdata[7:0]),
    .blk_left    (in_tdata[39:8]),
    .blk_right   (in_tdata[71:40]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_left    (out_left),
    .out_right   (out_right),
    .status      (status)
  );

  assign out_tdata = {out_right, out_left};

  `BF_ASSERT_NEXT(a_block_busy, clk, rst_n,
    in_tvalid && in_tready && (in_kind == bf_pkg::KIND_ENC || in_kind == bf_pkg::KIND_DEC),
    !in_tready)
  `BF_ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.out_load, status.out_free)
  `BF_ASSERT_IMPL(a_sbox_port_excl, clk, rst_n, cmd.s_clear, !cmd.s_wr && !in_tready)

endmodule

### src/bf_sbox.sv
// ---------------------------------------------------------------------------
// Blowfish S-box memory
// One 256 x 32 substitution box, one write port and one registered read port.
// ---------------------------------------------------------------------------
module bf_sbox (
  input  logic        clk,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [7:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [256];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/bf_datapath.sv
// ---------------------------------------------------------------------------
// Blowfish datapath
// P array, key buffer, S-boxes, block halves and the result register.
// ---------------------------------------------------------------------------
module bf_datapath #(
  parameter int MAX_KEY_BYTES = 80
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bf_pkg::bf_cmd_t                  cmd,
  input  logic [$clog2(MAX_KEY_BYTES)-1:0] key_wr_addr,
  input  logic [$clog2(MAX_KEY_BYTES)-1:0] key_rd_addr,
  input  logic [7:0]                       key_byte,
  input  logic [31:0]                      blk_left,
  input  logic [31:0]                      blk_right,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [31:0]                      out_left,
  output logic [31:0]                      out_right,
  output bf_pkg::bf_status_t               status
);

  logic [31:0] p_r [bf_pkg::P_LEN];
  logic [31:0] p_nxt [bf_pkg::P_LEN];
  logic [7:0]  key_mem [MAX_KEY_BYTES];
  logic [7:0]  key_q_r;
  logic [23:0] acc_r;
  logic [23:0] acc_nxt;
  logic [31:0] l_r, l_nxt, r_r, r_nxt;
  logic [31:0] out_left_r, out_right_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] p_sel;
  logic [31:0] s_q [4];
  logic [31:0] feistel;
  logic [31:0] l0, r0;

  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[key_wr_addr] <= key_byte;
    end
    key_q_r <= key_mem[key_rd_addr];
  end

  genvar b;
  generate
    for (b = 0; b < 4; b++) begin : g_box
      logic        we;
      logic [31:0] wdata;
      always_comb begin
        we = cmd.s_clear | (cmd.s_wr & (cmd.s_idx[9:8] == 2'(b)));
        if (cmd.s_clear) begin
          wdata = bf_pkg::S_INIT[{2'(b), cmd.s_idx[7:0]}];
        end else begin
          wdata = cmd.s_wr_hi ? r_r : l_r;
        end
      end
      bf_sbox u_sbox (
        .clk   (clk),
        .we    (we),
        .waddr (cmd.s_idx[7:0]),
        .wdata (wdata),
        .raddr (l_r[31-8*b -: 8]),
        .rdata (s_q[b])
      );
    end
  endgenerate

  assign p_sel   = p_r[cmd.p_idx];
  assign feistel = ((s_q[0] + s_q[1]) ^ s_q[2]) + s_q[3];

  always_comb begin
    p_nxt   = p_r;
    acc_nxt = acc_r;
    if (cmd.p_load_rom) begin
      p_nxt = bf_pkg::P_INIT;
    end
    if (cmd.key_shift) begin
      acc_nxt = {acc_r[15:0], key_q_r};
    end
    if (cmd.p_xor_key) begin
      p_nxt[cmd.p_idx] = p_r[cmd.p_idx] ^ {acc_r, key_q_r};
    end
    if (cmd.p_wr_pair) begin
      p_nxt[cmd.p_idx]        = l_r;
      p_nxt[cmd.p_idx | 5'd1] = r_r;
    end
  end

  always_comb begin
    unique case (cmd.blk_src)
      bf_pkg::SRC_INPUT: begin
        l0 = blk_left;
        r0 = blk_right;
      end
      bf_pkg::SRC_ZERO: begin
        l0 = '0;
        r0 = '0;
      end
      default: begin
        l0 = l_r;
        r0 = r_r;
      end
    endcase
    l_nxt = l_r;
    r_nxt = r_r;
    if (cmd.blk_start) begin
      l_nxt = l0 ^ p_sel;
      r_nxt = r0;
    end else if (cmd.round) begin
      l_nxt = r_r ^ feistel ^ p_sel;
      r_nxt = l_r;
    end else if (cmd.finish) begin
      l_nxt = r_r ^ p_sel;
      r_nxt = l_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
    l_r   <= l_nxt;
    r_r   <= r_nxt;
    if (cmd.out_load) begin
      out_left_r  <= l_r;
      out_right_r <= r_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left        = out_left_r;
  assign out_right       = out_right_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

### src/bf_ctrl.sv
// ---------------------------------------------------------------------------
// Blowfish controller
// Sequences table loads, key mixing, rounds and the key schedule.
// ---------------------------------------------------------------------------
module bf_ctrl #(
  parameter int MAX_KEY_BYTES = 80
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_kind,
  input  bf_pkg::bf_status_t               status,
  output bf_pkg::bf_cmd_t                  cmd,
  output logic [$clog2(MAX_KEY_BYTES)-1:0] key_wr_addr,
  output logic [$clog2(MAX_KEY_BYTES)-1:0] key_rd_addr
);

  localparam int KAW = $clog2(MAX_KEY_BYTES);
  localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KCW-1:0] KEY_MAX = KCW'(MAX_KEY_BYTES);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_KXOR  = 4'd2;
  localparam logic [3:0] ST_START = 4'd3;
  localparam logic [3:0] ST_WAIT  = 4'd4;
  localparam logic [3:0] ST_ROUND = 4'd5;
  localparam logic [3:0] ST_FIN   = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;
  localparam logic [3:0] ST_WRP   = 4'd8;
  localparam logic [3:0] ST_WRS0  = 4'd9;
  localparam logic [3:0] ST_WRS1  = 4'd10;

  localparam logic [9:0] CLR_LAST  = 10'd255;
  localparam logic [9:0] KXOR_END  = 10'(bf_pkg::KXOR_LEN);
  localparam logic [9:0] S_LAST    = 10'(bf_pkg::S_LEN - 2);
  localparam logic [3:0] RND_LAST  = 4'(bf_pkg::ROUNDS - 1);
  localparam logic [3:0] P_PAIRS   = 4'(bf_pkg::P_LEN / 2);

  logic [3:0]     state_r, state_nxt;
  logic [9:0]     cnt_r, cnt_nxt;
  logic [3:0]     rnd_r, rnd_nxt;
  logic [3:0]     wcnt_r, wcnt_nxt;
  logic           dec_r, dec_nxt;
  logic           sched_r, sched_nxt;
  logic [KCW-1:0] kcount_r, kcount_nxt;
  logic [KAW-1:0] j_r, j_nxt;
  logic [6:0]     sh;

  assign sh          = 7'(cnt_r - 10'd1);
  assign key_wr_addr = kcount_r[KAW-1:0];
  assign key_rd_addr = j_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rnd_nxt    = rnd_r;
    wcnt_nxt   = wcnt_r;
    dec_nxt    = dec_r;
    sched_nxt  = sched_r;
    kcount_nxt = kcount_r;
    j_nxt      = j_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.s_clear    = 1'b1;
        cmd.s_idx      = cnt_r;
        cmd.p_load_rom = 1'b1;
        if (cnt_r == CLR_LAST) begin
          cnt_nxt = '0;
          j_nxt   = '0;
          if (!sched_r) begin
            state_nxt = ST_IDLE;
          end else if (kcount_r != '0) begin
            state_nxt = ST_KXOR;
          end else begin
            state_nxt = ST_START;
          end
        end else begin
          cnt_nxt = cnt_r + 10'd1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_kind)
            bf_pkg::KIND_KEY: begin
              if (kcount_r < KEY_MAX) begin
                cmd.key_wr = 1'b1;
                kcount_nxt = kcount_r + KCW'(1);
              end
            end
            bf_pkg::KIND_SCHED: begin
              sched_nxt = 1'b1;
              dec_nxt   = 1'b0;
              cnt_nxt   = '0;
              wcnt_nxt  = '0;
              state_nxt = ST_INIT;
            end
            default: begin
              cmd.blk_start = 1'b1;
              cmd.blk_src   = bf_pkg::SRC_INPUT;
              dec_nxt       = (in_kind == bf_pkg::KIND_DEC);
              cmd.p_idx     = (in_kind == bf_pkg::KIND_DEC) ? bf_pkg::P_LAST
                                                              : bf_pkg::P_FIRST;
              rnd_nxt       = '0;
              state_nxt     = ST_WAIT;
            end
          endcase
        end
      end
      ST_KXOR: begin
        if (cnt_r != KXOR_END) begin
          j_nxt = (KCW'(j_r) + KCW'(1) == kcount_r) ? '0 : j_r + KAW'(1);
        end
        if (cnt_r != '0) begin
          cmd.key_shift = 1'b1;
          cmd.p_idx     = 5'(sh[6:2]);
          cmd.p_xor_key = (sh[1:0] == 2'd3);
        end
        if (cnt_r == KXOR_END) begin
          cnt_nxt   = '0;
          state_nxt = ST_START;
        end else begin
          cnt_nxt = cnt_r + 10'd1;
        end
      end
      ST_START: begin
        cmd.blk_start = 1'b1;
        cmd.blk_src   = (wcnt_r == '0 && cnt_r == '0) ? bf_pkg::SRC_ZERO
                                                      : bf_pkg::SRC_CHAIN;
        cmd.p_idx     = bf_pkg::P_FIRST;
        rnd_nxt       = '0;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.p_idx = dec_r ? 5'(5'd16 - {1'b0, rnd_r}) : 5'({1'b0, rnd_r} + 5'd1);
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          rnd_nxt   = rnd_r + 4'd1;
          state_nxt = ST_WAIT;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        cmd.p_idx  = dec_r ? bf_pkg::P_FIRST : bf_pkg::P_LAST;
        if (!sched_r) begin
          state_nxt = ST_OUT;
        end else if (wcnt_r != P_PAIRS) begin
          state_nxt = ST_WRP;
        end else begin
          state_nxt = ST_WRS0;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_WRP: begin
        cmd.p_wr_pair = 1'b1;
        cmd.p_idx     = {wcnt_r, 1'b0};
        wcnt_nxt      = wcnt_r + 4'd1;
        state_nxt     = ST_START;
      end
      ST_WRS0: begin
        cmd.s_wr  = 1'b1;
        cmd.s_idx = cnt_r;
        state_nxt = ST_WRS1;
      end
      ST_WRS1: begin
        cmd.s_wr    = 1'b1;
        cmd.s_wr_hi = 1'b1;
        cmd.s_idx   = cnt_r | 10'd1;
        if (cnt_r == S_LAST) begin
          cnt_nxt    = '0;
          kcount_nxt = '0;
          sched_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 10'd2;
          state_nxt = ST_START;
        end
      end
      default: begin
        state_nxt = ST_INIT;
        cnt_nxt   = '0;
        sched_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      cnt_r    <= '0;
      rnd_r    <= '0;
      wcnt_r   <= '0;
      dec_r    <= 1'b0;
      sched_r  <= 1'b0;
      kcount_r <= '0;
      j_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rnd_r    <= rnd_nxt;
      wcnt_r   <= wcnt_nxt;
      dec_r    <= dec_nxt;
      sched_r  <= sched_nxt;
      kcount_r <= kcount_nxt;
      j_r      <= j_nxt;
    end
  end

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// Blowfish block cipher testbench
// Sends key bytes, schedules and cipher blocks through the input stream.
// Each block is predicted by a cipher model held here, and each output
// transfer is checked against it in order. Random bursts of idle and stall
// cycles appear on both streams, except in the closing part.
// ---------------------------------------------------------------------------
module testbench;

  localparam int KEY_MAX    = 80;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] right;
    logic [31:0] left;
  } block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  logic [31:0] p_cur [bf_pkg::P_LEN];
  logic [31:0] s_cur [bf_pkg::S_LEN];
  logic [7:0]  key_bytes [KEY_MAX];
  int          key_len;
  block_t      blocks_due [$];
  int          error_count = 0;
  bit          idle_on = 1'b1;
  int          quiet_cycles = 0;
  int          stall_left = 0;

  blowfish_block_cipher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] round_f(logic [31:0] x);
    return ((s_cur[x[31:24]] + s_cur[256 + x[23:16]]) ^ s_cur[512 + x[15:8]])
      + s_cur[768 + x[7:0]];
  endfunction

  function automatic block_t cipher_block(block_t b, bit decrypt);
    logic [31:0] l, r, t;
    l = b.left ^ p_cur[decrypt ? bf_pkg::P_LEN - 1 : 0];
    r = b.right;
    for (int i = 1; i <= bf_pkg::ROUNDS; i++) begin
      r = r ^ round_f(l) ^ p_cur[decrypt ? bf_pkg::P_LEN - 1 - i : i];
      t = l; l = r; r = t;
    end
    r = r ^ p_cur[decrypt ? 0 : bf_pkg::P_LEN - 1];
    return '{right: l, left: r};
  endfunction

  function automatic void run_schedule();
    block_t b;
    int j;
    j = 0;
    for (int i = 0; i < bf_pkg::P_LEN; i++) p_cur[i] = bf_pkg::P_INIT[i];
    for (int i = 0; i < bf_pkg::S_LEN; i++) s_cur[i] = bf_pkg::S_INIT[i];
    if (key_len > 0) begin
      for (int i = 0; i < bf_pkg::P_LEN; i++) begin
        p_cur[i] ^= {key_bytes[j], key_bytes[(j + 1) % key_len],
                     key_bytes[(j + 2) % key_len], key_bytes[(j + 3) % key_len]};
        j = (j + 4) % key_len;
      end
    end
    b = '0;
    for (int i = 0; i < bf_pkg::P_LEN; i += 2) begin
      b = cipher_block(b, 1'b0);
      p_cur[i] = b.left; p_cur[i + 1] = b.right;
    end
    for (int i = 0; i < bf_pkg::S_LEN; i += 2) begin
      b = cipher_block(b, 1'b0);
      s_cur[i] = b.left; s_cur[i + 1] = b.right;
    end
    key_len = 0;
  endfunction

  task automatic send(logic [1:0] kind, logic [7:0] kb, logic [31:0] l, logic [31:0] r);
    int gap;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(7, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l, kb};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    case (kind)
      bf_pkg::KIND_KEY: begin
        if (key_len < KEY_MAX) begin
          key_bytes[key_len] = kb;
          key_len++;
        end
      end
      bf_pkg::KIND_SCHED: run_schedule();
      bf_pkg::KIND_ENC:   blocks_due.push_back(cipher_block('{right: r, left: l}, 1'b0));
      default:            blocks_due.push_back(cipher_block('{right: r, left: l}, 1'b1));
    endcase
  endtask

  task automatic send_block(logic [1:0] kind);
    send(kind, 8'($urandom), $urandom, $urandom);
  endtask

  task automatic test_unkeyed();
    send(bf_pkg::KIND_ENC, 8'hff, 32'h0, 32'h0);
    send(bf_pkg::KIND_ENC, 8'h00, 32'hffffffff, 32'hffffffff);
    send(bf_pkg::KIND_DEC, 8'hff, 32'h0, 32'hffffffff);
    send(bf_pkg::KIND_DEC, 8'h00, 32'hffffffff, 32'h0);
    send_block(bf_pkg::KIND_ENC);
  endtask

  task automatic test_empty_key();
    send(bf_pkg::KIND_SCHED, 8'hff, 32'hffffffff, 32'hffffffff);
    send(bf_pkg::KIND_ENC, 8'h00, 32'h01234567, 32'h89abcdef);
    send(bf_pkg::KIND_DEC, 8'h00, 32'hffffffff, 32'h0);
  endtask

  task automatic test_short_keys();
    send(bf_pkg::KIND_KEY, 8'h00, 32'hffffffff, 32'hffffffff);
    send(bf_pkg::KIND_SCHED, 8'h00, 32'h0, 32'h0);
    send(bf_pkg::KIND_ENC, 8'h00, 32'h0, 32'h0);
    send(bf_pkg::KIND_KEY, 8'hff, 32'h0, 32'h0);
    send(bf_pkg::KIND_KEY, 8'ha5, 32'h0, 32'h0);
    send(bf_pkg::KIND_KEY, 8'h5a, 32'h0, 32'h0);
    send(bf_pkg::KIND_SCHED, 8'h00, 32'h0, 32'h0);
    send(bf_pkg::KIND_DEC, 8'h00, 32'hffffffff, 32'hffffffff);
  endtask

  task automatic test_key_overflow();
    for (int i = 0; i < KEY_MAX + 6; i++) begin
      send(bf_pkg::KIND_KEY, 8'($urandom), $urandom, $urandom);
    end
    send(bf_pkg::KIND_SCHED, 8'h00, 32'h0, 32'h0);
    send_block(bf_pkg::KIND_ENC);
    send_block(bf_pkg::KIND_DEC);
  endtask

  task automatic random_sessions(int sessions);
    int n;
    for (int s = 0; s < sessions; s++) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(90, 60) : $urandom_range(16);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(15) == 0) send_block(2'($urandom_range(3, 2)));
        else send(bf_pkg::KIND_KEY, 8'($urandom), $urandom, $urandom);
      end
      send(bf_pkg::KIND_SCHED, 8'($urandom), $urandom, $urandom);
      n = $urandom_range(60, 20);
      for (int i = 0; i < n; i++) send_block(2'($urandom_range(3, 2)));
    end
  endtask

  task automatic test_random_traffic();
    random_sessions(18);
  endtask

  task automatic test_no_idling();
    idle_on = 1'b0;
    random_sessions(2);
  endtask

  always @(posedge clk) begin
    block_t got, want;
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (blocks_due.size() == 0) begin
        $error("out transfer with no block expected: %h", out_tdata);
        error_count++;
      end else begin
        want = blocks_due.pop_front();
        if (got.left !== want.left) begin
          $error("out_left expected %h actual %h", want.left, got.left);
          error_count++;
        end
        if (got.right !== want.right) begin
          $error("out_right expected %h actual %h", want.right, got.right);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(4) == 0) begin
      stall_left <= $urandom_range(6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    key_len = 0;
    for (int i = 0; i < bf_pkg::P_LEN; i++) p_cur[i] = bf_pkg::P_INIT[i];
    for (int i = 0; i < bf_pkg::S_LEN; i++) s_cur[i] = bf_pkg::S_INIT[i];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_unkeyed();
    test_empty_key();
    test_short_keys();
    test_key_overflow();
    test_random_traffic();
    test_no_idling();
    in_tvalid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
